// ===== hw/rtl/efbd_pkg.sv =====
// ----------------------------------------------------------------------------
// efbd_pkg
// types and constants shared by the escape-framed byte deframer
// ----------------------------------------------------------------------------
`default_nettype none

package efbd_pkg;

    localparam int BYTE_W      = 8;
    localparam int MAXLEN_W    = 7;
    localparam int POS_W       = 6;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [1:0] REG_ESCAPE_CODE = 2'd0;
    localparam logic [1:0] REG_START_CODE  = 2'd1;
    localparam logic [1:0] REG_END_CODE    = 2'd2;
    localparam logic [1:0] REG_MAX_LENGTH  = 2'd3;

    localparam logic [BYTE_W-1:0]   ESCAPE_CODE_RST = 8'd92;
    localparam logic [BYTE_W-1:0]   START_CODE_RST  = 8'd48;
    localparam logic [BYTE_W-1:0]   END_CODE_RST    = 8'd49;
    localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RST  = 7'd64;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/escape_framed_byte_deframer.sv =====
// ----------------------------------------------------------------------------
// escape_framed_byte_deframer
// receive-side deframer for escape byte stuffing with a frame buffer memory
// ----------------------------------------------------------------------------
// Bytes from the line arrive as items on the s_ channel, one byte each.
// Data bytes and escaped literal escapes are written into the frame memory
// at the fill count; escape plus start rewinds the count. Escape plus end
// reads the stored frame, cut to max_length, out on the m_ channel as one
// item per byte, with byte_index, frame_length and tlast on the final byte.
// Ordinary bytes are taken every cycle while idle. An end marker that hands
// out L > 0 bytes holds s_tready low while its bytes are read out: the first
// memory read is issued in the cycle that takes the marker, and while the
// receiver takes an item every cycle, one byte per cycle moves from the read
// data register into the output register. When the receiver stalls, the
// readout waits with the output item held; after the last byte is loaded
// the block takes input again even if that item is still waiting. The user
// must write the registers through the APB port only while the block is
// idle; the block itself does not enforce it. Reset clears the escape flag,
// the fill count, the output valid and the registers to their defaults; the
// frame memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_framed_byte_deframer #(
    parameter int FRAME_DEPTH = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // apb configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [efbd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [efbd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [efbd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    // received bytes
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [efbd_pkg::IN_TDATA_W-1:0]   s_tdata,   // [7:0] rx_byte
    // frame bytes
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [efbd_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [7:0] frame_byte,
                                                              // [13:8] byte_index,
                                                              // [19:14] frame_length
    output logic                                   m_tlast
);

    import efbd_pkg::*;

    localparam int AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam logic [AW-1:0] FILL_MAX = AW'(FRAME_DEPTH - 1);

    // configuration registers
    logic [BYTE_W-1:0]   escape_code_reg;
    logic [BYTE_W-1:0]   start_code_reg;
    logic [BYTE_W-1:0]   end_code_reg;
    logic [MAXLEN_W-1:0] max_length_reg;

    // control state
    state_t          state_reg, state_next;
    logic            escape_pending_reg;
    logic [AW-1:0]   fill_count_reg;
    logic [AW-1:0]   idx_reg;
    logic [AW-1:0]   len_reg;

    // frame memory
    logic [BYTE_W-1:0] frame_store [FRAME_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // output register
    logic              m_tvalid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [AW-1:0]     out_index_reg;
    logic [AW-1:0]     out_length_reg;
    logic              out_last_reg;

    logic            cfg_wr;
    logic            in_acc;
    logic [BYTE_W-1:0] rx_byte;
    logic            is_escape;
    logic            store_en;
    logic            clear_en;
    logic            end_en;
    logic            emit_en;
    logic [AW-1:0]   emit_len;
    logic            out_free;
    logic            load_out;
    logic            rd_last;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;

    // apb
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ESCAPE_CODE: prdata = APB_DATA_W'(escape_code_reg);
            REG_START_CODE:  prdata = APB_DATA_W'(start_code_reg);
            REG_END_CODE:    prdata = APB_DATA_W'(end_code_reg);
            REG_MAX_LENGTH:  prdata = APB_DATA_W'(max_length_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_code_reg <= ESCAPE_CODE_RST;
            start_code_reg  <= START_CODE_RST;
            end_code_reg    <= END_CODE_RST;
            max_length_reg  <= MAX_LENGTH_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_ESCAPE_CODE: escape_code_reg <= pwdata[BYTE_W-1:0];
                REG_START_CODE:  start_code_reg  <= pwdata[BYTE_W-1:0];
                REG_END_CODE:    end_code_reg    <= pwdata[BYTE_W-1:0];
                REG_MAX_LENGTH:  max_length_reg  <= pwdata[MAXLEN_W-1:0];
                default:         ;
            endcase
        end
    end

    // byte decode
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign rx_byte   = s_tdata[BYTE_W-1:0];
    assign is_escape = (rx_byte == escape_code_reg);

    always_comb
    begin
        store_en = 1'b0;
        clear_en = 1'b0;
        end_en   = 1'b0;
        if (in_acc)
        begin
            priority if (is_escape)
                store_en = escape_pending_reg;
            else if (escape_pending_reg)
            begin
                priority if (rx_byte == start_code_reg)
                    clear_en = 1'b1;
                else if (rx_byte == end_code_reg)
                    end_en = 1'b1;
                else
                    store_en = 1'b1;
            end
            else
                store_en = 1'b1;
        end
    end

    // frame length after truncation
    always_comb
    begin
        if ({{(MAXLEN_W > AW ? MAXLEN_W - AW : 0){1'b0}}, fill_count_reg} >
            MAXLEN_W'(max_length_reg))
            emit_len = max_length_reg[AW-1:0];
        else
            emit_len = fill_count_reg;
    end

    assign emit_en  = end_en && (emit_len != '0);
    assign out_free = !m_tvalid_reg || m_tready;
    assign load_out = (state_reg == ST_READ) && out_free;
    assign rd_last  = (idx_reg == len_reg - AW'(1));
    assign rd_en    = emit_en || (load_out && !rd_last);
    assign rd_addr  = (state_reg == ST_IDLE) ? '0 : idx_reg + AW'(1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (emit_en) state_next = ST_READ;
            ST_READ: if (load_out && rd_last) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            escape_pending_reg <= 1'b0;
            fill_count_reg     <= '0;
            m_tvalid_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
                escape_pending_reg <= is_escape && !escape_pending_reg;
            if (clear_en)
                fill_count_reg <= '0;
            else if (store_en && fill_count_reg != FILL_MAX)
                fill_count_reg <= fill_count_reg + AW'(1);
            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // readout position
    always_ff @(posedge clk)
    begin
        if (emit_en)
        begin
            idx_reg <= '0;
            len_reg <= emit_len;
        end
        else if (load_out)
            idx_reg <= idx_reg + AW'(1);
        if (load_out)
        begin
            out_byte_reg   <= rd_data_reg;
            out_index_reg  <= idx_reg;
            out_length_reg <= len_reg;
            out_last_reg   <= rd_last;
        end
    end

    // frame memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (store_en)
            frame_store[fill_count_reg] <= rx_byte;
        if (rd_en)
            rd_data_reg <= frame_store[rd_addr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0000, POS_W'(out_length_reg), POS_W'(out_index_reg), out_byte_reg};

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FILL_MAX)
        else $error("fill count beyond frame depth");

    a_read_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (len_reg != '0) && (idx_reg < len_reg))
        else $error("readout position outside frame");

    a_no_store_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !store_en && !clear_en)
        else $error("frame memory modified during readout");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[13:8] + 6'd1 == m_tdata[19:14]))
        else $error("last item not at end of frame");

    a_emit_enters_read: assert property (@(posedge clk) disable iff (!rst_n)
        emit_en |=> (state_reg == ST_READ))
        else $error("end marker did not start readout");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the escape-framed byte deframer
// ----------------------------------------------------------------------------
// Received bytes go in on the s_ stream. A local deframer tracks the escape
// flag, the fill count and the frame memory, and queues the frame bytes that
// each end marker should release. The m_ stream is checked against that
// queue. A short table of directed bytes runs first, then randomly built
// frames with noise, under several code and length settings written over
// APB between phases. Both sides idle at random, and the receiver holds off
// once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import efbd_pkg::*;

    localparam int DEPTH       = 64;
    localparam int MAX_GAP     = 12;
    localparam int HOLD_AT     = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 3000;

    localparam logic [BYTE_W-1:0] ESC = ESCAPE_CODE_RST;
    localparam logic [BYTE_W-1:0] STA = START_CODE_RST;
    localparam logic [BYTE_W-1:0] FIN = END_CODE_RST;

    typedef struct packed {
        logic [BYTE_W-1:0] fbyte;
        logic [POS_W-1:0]  idx;
        logic [POS_W-1:0]  flen;
        logic              last;
    } frame_out_t;

    typedef struct {
        logic [BYTE_W-1:0] rx;
        bit                typed;
        int                n;
        logic [BYTE_W-1:0] fbyte;
        logic [POS_W-1:0]  idx;
        logic [POS_W-1:0]  flen;
        logic              last;
    } step_row_t;

    typedef struct {
        logic [BYTE_W-1:0]   esc;
        logic [BYTE_W-1:0]   sta;
        logic [BYTE_W-1:0]   fin;
        logic [MAXLEN_W-1:0] maxlen;
        int                  budget;
    } code_set_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [7:0] rx_byte
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // [7:0] frame_byte, [13:8] byte_index,
                                             // [19:14] frame_length
    logic                   m_tlast;

    // local copy of the deframer state and registers
    logic [BYTE_W-1:0]   cfg_esc    = ESCAPE_CODE_RST;
    logic [BYTE_W-1:0]   cfg_start  = START_CODE_RST;
    logic [BYTE_W-1:0]   cfg_end    = END_CODE_RST;
    logic [MAXLEN_W-1:0] cfg_maxlen = MAX_LENGTH_RST;
    logic                esc_armed  = 1'b0;
    int                  fill_cnt   = 0;
    logic [BYTE_W-1:0]   frame_mem [DEPTH];

    frame_out_t frame_q [$];
    int         errors   = 0;
    int         sent_cnt = 0;
    int         rcv_cnt  = 0;
    int         idle_cycles = 0;
    bit         snd_burst = 1'b0;
    bit         rcv_burst = 1'b0;

    step_row_t directed [21] = '{
        '{ESC,   1'b0, 0, 8'h00, 6'd0, 6'd0, 1'b0},
        '{FIN,   1'b1, 0, 8'h00, 6'd0, 6'd0, 1'b0},   // empty frame after reset
        '{ESC,   1'b0, 0, 8'h00, 6'd0, 6'd0, 1'b0},
        '{STA,   1'b0, 0, 8'h00, 6'd0, 6'd0, 1'b0},
        '{8'h00, 1'b0, 0, 8'h00, 6'd0, 6'd0, 1'b0},
        '{ESC,   1'b0, 0, 8'h00, 6'd0, 6'd0, 1'b0},
        '{FIN,   1'b1, 1, 8'h00, 6'd0, 6'd1, 1'b1},
        '{8'hFF, 1'b0, 0, 8'h00, 6'd0, 6'd0, 1'b0},
        '{ESC,   1'b0, 0, 8'h00, 6'd0, 6'd0, 1'b0},
        '{FIN,   1'b0, 0, 8'h00, 6'd0, 6'd0, 1'b0},   // end without clearing
        '{ESC,   1'b0, 0, 8'h00, 6'd0, 6'd0, 1'b0},
        '{ESC,   1'b0, 0, 8'h00, 6'd0, 6'd0, 1'b0},   // literal escape
        '{ESC,   1'b0, 0, 8'h00, 6'd0, 6'd0, 1'b0},
        '{8'h37, 1'b0, 0, 8'h00, 6'd0, 6'd0, 1'b0},   // escape plus plain byte
        '{8'h80, 1'b0, 0, 8'h00, 6'd0, 6'd0, 1'b0},
        '{ESC,   1'b0, 0, 8'h00, 6'd0, 6'd0, 1'b0},
        '{FIN,   1'b0, 0, 8'h00, 6'd0, 6'd0, 1'b0},
        '{ESC,   1'b0, 0, 8'h00, 6'd0, 6'd0, 1'b0},
        '{STA,   1'b0, 0, 8'h00, 6'd0, 6'd0, 1'b0},
        '{ESC,   1'b0, 0, 8'h00, 6'd0, 6'd0, 1'b0},
        '{FIN,   1'b1, 0, 8'h00, 6'd0, 6'd0, 1'b0}
    };

    code_set_t code_sets [6] = '{
        '{8'd92, 8'd48, 8'd49, 7'd64, 120},
        '{8'h00, 8'hFF, 8'h80, 7'd1,  60},
        '{8'hFF, 8'h00, 8'h01, 7'd0,  30},    // nothing is ever released
        '{8'h7E, 8'h5A, 8'h5A, 7'd40, 30},    // start wins over end
        '{8'hA5, 8'h11, 8'h22, 7'd5,  110},
        '{8'h10, 8'h02, 8'h03, 7'd64, 110}
    };

    escape_framed_byte_deframer #(
        .FRAME_DEPTH(DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    function automatic void deframe(input logic [BYTE_W-1:0] b);
        int n;
        int i;
        if (b == cfg_esc)
        begin
            if (!esc_armed)
            begin
                esc_armed = 1'b1;
                return;
            end
            esc_armed = 1'b0;
        end
        else if (esc_armed)
        begin
            esc_armed = 1'b0;
            if (b == cfg_start)
            begin
                fill_cnt = 0;
                return;
            end
            if (b == cfg_end)
            begin
                n = (fill_cnt > int'(cfg_maxlen)) ? int'(cfg_maxlen) : fill_cnt;
                for (i = 0; i < n; i++)
                    frame_q.push_back('{frame_mem[i], POS_W'(i), POS_W'(n), (i == n - 1)});
                return;
            end
        end
        frame_mem[fill_cnt] = b;
        fill_cnt = (fill_cnt + 1 >= DEPTH) ? DEPTH - 1 : fill_cnt + 1;
    endfunction

    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 15) == 0)
            burst = ~burst;
        return burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = draw_gap(snd_burst);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        sent_cnt++;
    endtask

    task automatic feed(input logic [BYTE_W-1:0] b);
        send_byte(b);
        deframe(b);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (frame_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] val);
        logic [APB_DATA_W-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ESCAPE_CODE: cfg_esc    = val[BYTE_W-1:0];
            REG_START_CODE:  cfg_start  = val[BYTE_W-1:0];
            REG_END_CODE:    cfg_end    = val[BYTE_W-1:0];
            REG_MAX_LENGTH:  cfg_maxlen = val[MAXLEN_W-1:0];
            default: ;
        endcase
        want = (idx == REG_MAX_LENGTH) ? APB_DATA_W'(val[MAXLEN_W-1:0])
                                       : APB_DATA_W'(val[BYTE_W-1:0]);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
        begin
            $error("prdata: expected %0d, got %0d", want, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic gen_frame(input bit force_long);
        int                len;
        int                r;
        logic [BYTE_W-1:0] d;
        if (!force_long && $urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 8))
                feed(($urandom_range(0, 3) == 0) ? cfg_esc : BYTE_W'($urandom_range(0, 255)));
            return;
        end
        if (force_long)
            len = 70;
        else if ($urandom_range(0, 11) == 0)
            len = $urandom_range(40, 72);
        else
            len = $urandom_range(0, 7);
        if ($urandom_range(0, 5) != 0)
        begin
            feed(cfg_esc);
            feed(cfg_start);
        end
        repeat (len)
        begin
            r = $urandom_range(0, 15);
            d = BYTE_W'($urandom_range(0, 255));
            if (r == 0)
            begin
                feed(cfg_esc);
                feed(cfg_esc);
            end
            else if (r == 1)
            begin
                feed(cfg_esc);
                feed(d);
            end
            else
                feed(d);
        end
        if ($urandom_range(0, 7) != 0)
        begin
            feed(cfg_esc);
            feed(cfg_end);
        end
    endtask

    // frame byte checker
    initial
    begin
        int         gap;
        frame_out_t got;
        frame_out_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(rcv_burst);
            if (rcv_cnt == HOLD_AT)
                gap = HOLD_CYCLES;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            rcv_cnt++;
            got = '{m_tdata[7:0], m_tdata[13:8], m_tdata[19:14], m_tlast};
            if (frame_q.size() == 0)
            begin
                $error("unexpected frame item: data %h, last %b", m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                want = frame_q.pop_front();
                if (got.fbyte !== want.fbyte)
                begin
                    $error("frame_byte: expected %0d, got %0d", want.fbyte, got.fbyte);
                    errors++;
                end
                if (got.idx !== want.idx)
                begin
                    $error("byte_index: expected %0d, got %0d", want.idx, got.idx);
                    errors++;
                end
                if (got.flen !== want.flen)
                begin
                    $error("frame_length: expected %0d, got %0d", want.flen, got.flen);
                    errors++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int first;
        int n0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
        begin
            send_byte(directed[k].rx);
            n0 = frame_q.size();
            deframe(directed[k].rx);
            if (directed[k].typed)
            begin
                while (frame_q.size() > n0)
                    void'(frame_q.pop_back());
                if (directed[k].n == 1)
                    frame_q.push_back('{directed[k].fbyte, directed[k].idx,
                                        directed[k].flen, directed[k].last});
            end
        end

        foreach (code_sets[p])
        begin
            drain();
            write_reg(REG_ESCAPE_CODE, APB_DATA_W'(code_sets[p].esc));
            write_reg(REG_START_CODE,  APB_DATA_W'(code_sets[p].sta));
            write_reg(REG_END_CODE,    APB_DATA_W'(code_sets[p].fin));
            write_reg(REG_MAX_LENGTH,  APB_DATA_W'(code_sets[p].maxlen));
            first = sent_cnt;
            // overflow frame up front where the whole store can come out
            gen_frame(code_sets[p].maxlen == MAX_LENGTH_RST
                      && code_sets[p].sta != code_sets[p].fin);
            while (sent_cnt - first < code_sets[p].budget)
                gen_frame(1'b0);
        end

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
